// ===== design/fisr_pkg.sv =====
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared types, constants and binary32 arithmetic helpers for the fast
// reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] FISR_MAGIC = 32'h5f3759df;
  localparam logic [31:0] QUIET_BIT  = 32'h00400000;
  localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
  localparam logic [31:0] POS_INF    = 32'h7f800000;
  localparam logic [31:0] FP_HALF    = 32'h3f000000;
  localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;

  // values that ride along with each item
  typedef struct packed {
    logic        ovr;       // result is forced to ovr_word
    logic [31:0] ovr_word;
    logic [31:0] y;         // first guess
  } side_t;

  typedef struct packed {
    logic               sign;
    logic               spec;
    logic [31:0]        spec_word;
    logic [47:0]        prod;
    logic signed [10:0] exp;
  } mul_mid_t;

  typedef struct packed {
    logic        sign;
    logic        spec;
    logic [31:0] spec_word;
    logic [27:0] sum;
    logic [8:0]  e;
  } add_mid_t;

  function automatic logic [5:0] clz48(input logic [47:0] p);
    logic [5:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && p[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] clz27(input logic [26:0] p);
    logic [4:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && p[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // round to nearest even and pack; e >= 1, mant[23] is the hidden bit
  // (zero for a subnormal at e == 1)
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [10:0] e,
                                             input logic [23:0] mant,
                                             input logic g,
                                             input logic st);
    logic        up;
    logic [24:0] mr;
    logic [31:0] mag;
    up  = g & (st | mant[0]);
    mr  = {1'b0, mant} + 25'(up);
    mag = (32'(e - 11'sd1) << 23) + 32'(mr);
    if (mag >= POS_INF) begin
      mag = POS_INF;
    end
    return {sign, mag[30:0]};
  endfunction

  function automatic mul_mid_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
    mul_mid_t   m;
    logic [7:0] ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic       a_zero, b_zero, a_inf, b_inf;
    ea     = a[30:23];
    eb     = b[30:23];
    eae    = (ea == 8'd0) ? 8'd1 : ea;
    ebe    = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {(ea != 8'd0), a[22:0]};
    mb     = {(eb != 8'd0), b[22:0]};
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    a_inf  = (ea == 8'hff);
    b_inf  = (eb == 8'hff);
    m.sign = a[31] ^ b[31];
    m.prod = 48'(ma) * 48'(mb);
    m.exp  = $signed({3'b000, eae}) + $signed({3'b000, ebe}) - 11'sd126;
    m.spec = 1'b0;
    m.spec_word = '0;
    if (a_inf || b_inf) begin
      m.spec = 1'b1;
      m.spec_word = (a_zero || b_zero) ? CANON_NAN : {m.sign, POS_INF[30:0]};
    end else if (a_zero || b_zero) begin
      m.spec = 1'b1;
      m.spec_word = {m.sign, 31'd0};
    end
    return m;
  endfunction

  function automatic logic [31:0] fp_mul_post(input mul_mid_t m);
    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [10:0] e;
    logic [10:0]        shw;
    logic [63:0]        val, val2;
    logic               lost, g, st;
    logic [23:0]        mant;
    lz   = clz48(m.prod);
    pn   = m.prod << lz;
    e    = m.exp - $signed({5'b00000, lz});
    val  = {pn, 16'd0};
    val2 = '0;
    lost = 1'b0;
    if (e >= 11'sd1) begin
      mant = pn[47:24];
      g    = pn[23];
      st   = |pn[22:0];
    end else begin
      shw = 11'(11'sd1 - e);
      if (shw >= 11'd64) begin
        val2 = '0;
        lost = |val;
      end else begin
        val2 = val >> shw[5:0];
        lost = |(val & ((64'd1 << shw[5:0]) - 64'd1));
      end
      mant = val2[63:40];
      g    = val2[39];
      st   = (|val2[38:0]) | lost;
      e    = 11'sd1;
    end
    return m.spec ? m.spec_word : round_pack(m.sign, e, mant, g, st);
  endfunction

  function automatic add_mid_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
    add_mid_t    m;
    logic [31:0] big, lit;
    logic [7:0]  ebe, ele, d;
    logic [26:0] a27, b27, bs;
    logic        sub;
    if (b[30:0] > a[30:0]) begin
      big = b;
      lit = a;
    end else begin
      big = a;
      lit = b;
    end
    ebe = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    ele = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
    d   = ebe - ele;
    a27 = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    b27 = {(lit[30:23] != 8'd0), lit[22:0], 3'b000};
    if (d >= 8'd27) begin
      bs = {26'd0, |b27};
    end else begin
      bs = (b27 >> d[4:0]) | 27'(|(b27 & ((27'd1 << d[4:0]) - 27'd1)));
    end
    sub    = big[31] ^ lit[31];
    m.sign = big[31];
    m.sum  = sub ? ({1'b0, a27} - {1'b0, bs}) : ({1'b0, a27} + {1'b0, bs});
    m.e    = {1'b0, ebe};
    m.spec = 1'b0;
    m.spec_word = '0;
    if (big[30:23] == 8'hff) begin
      m.spec = 1'b1;
      m.spec_word = ((lit[30:23] == 8'hff) && sub) ? CANON_NAN : big;
    end else if (big[30:0] == 31'd0) begin
      m.spec = 1'b1;
      m.spec_word = {big[31] & lit[31], 31'd0};
    end else if (sub && (m.sum == 28'd0)) begin
      m.spec = 1'b1;
      m.spec_word = '0;
    end
    return m;
  endfunction

  function automatic logic [31:0] fp_add_post(input add_mid_t m);
    logic [26:0] s;
    logic [4:0]  lz;
    logic [8:0]  e, sh;
    lz = clz27(m.sum[26:0]);
    sh = '0;
    if (m.sum[27]) begin
      s = {m.sum[27:2], m.sum[1] | m.sum[0]};
      e = m.e + 9'd1;
    end else begin
      sh = (9'(lz) > (m.e - 9'd1)) ? (m.e - 9'd1) : 9'(lz);
      s  = m.sum[26:0] << sh[4:0];
      e  = m.e - sh;
    end
    return m.spec ? m.spec_word
                  : round_pack(m.sign, $signed({2'b00, e}), s[26:3], s[2], |s[1:0]);
  endfunction

endpackage

// ===== design/fast_inverse_square_root_top.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_square_root_top
// Throughput: one item per cycle while no finished result is stalled; set
// by the 11-stage pipeline, every stage of which takes a new item each cycle.
// Output stall freezes the whole pipeline in place; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits; no warm-up needed.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_top import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);

  // Stage map:
  //   1      guess y = magic - (x >>> 1), NaN override picked here
  //   2-3    half = 0.5 * x
  //   4-5    t = half * y
  //   6-7    u = t * y
  //   8-9    v = 1.5 - u
  //   10-11  r = y * v  (output register)
  // The side struct carries y and the override word down the pipe.

  logic        adv;
  logic        g_valid, m1_valid, m2_valid, m3_valid, a_valid, m4_valid;
  logic [31:0] g_x, m1_p, m2_p, m3_p, a_s, m4_p;
  side_t       g_side, m1_side, m2_side, m3_side, a_side, m4_side;

  // global advance: hold everything while a finished result is stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  fisr_guess u_guess (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(in_valid), .x_in(value_bits),
    .out_valid(g_valid), .x(g_x), .side(g_side)
  );

  fisr_fmul u_half (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(g_valid), .a(g_x), .b(FP_HALF), .side_in(g_side),
    .out_valid(m1_valid), .p(m1_p), .side(m1_side)
  );

  fisr_fmul u_hy (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(m1_valid), .a(m1_p), .b(m1_side.y), .side_in(m1_side),
    .out_valid(m2_valid), .p(m2_p), .side(m2_side)
  );

  fisr_fmul u_hyy (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(m2_valid), .a(m2_p), .b(m2_side.y), .side_in(m2_side),
    .out_valid(m3_valid), .p(m3_p), .side(m3_side)
  );

  // 1.5 - u as 1.5 + (-u)
  fisr_fadd u_sub (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(m3_valid), .a(FP_THREE_HALVES), .b({~m3_p[31], m3_p[30:0]}),
    .side_in(m3_side),
    .out_valid(a_valid), .s(a_s), .side(a_side)
  );

  fisr_fmul u_final (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(a_valid), .a(a_side.y), .b(a_s), .side_in(a_side),
    .out_valid(m4_valid), .p(m4_p), .side(m4_side)
  );

  assign out_valid   = m4_valid;
  // NaN input or NaN guess bypasses the arithmetic
  assign result_bits = m4_side.ovr ? m4_side.ovr_word : m4_p;

  // stalled output freezes inner stages
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(g_x) && $stable(m2_p) && $stable(a_s)))
    else $error("pipeline moved during output stall");

  // override words are always quiet NaNs
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m4_side.ovr) |-> (result_bits[22] && (result_bits[30:23] == 8'hff)))
    else $error("override result is not a quiet NaN");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("valid result right after reset");

endmodule

// ===== design/fisr_guess.sv =====
// ----------------------------------------------------------------------------
// fisr_guess
// Bit-level first guess and NaN override detection, one register stage.
// ----------------------------------------------------------------------------
module fisr_guess import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] x_in,
  output logic        out_valid,
  output logic [31:0] x,
  output side_t       side
);

  logic [31:0] y_c;
  logic        x_nan, y_nan;
  side_t       side_next;

  always_comb begin
    y_c   = FISR_MAGIC - {x_in[31], x_in[31:1]};
    x_nan = (x_in[30:23] == 8'hff) && (x_in[22:0] != 23'd0);
    y_nan = (y_c[30:23] == 8'hff) && (y_c[22:0] != 23'd0);
    side_next.y        = y_c;
    side_next.ovr      = x_nan | y_nan;
    side_next.ovr_word = x_nan ? (x_in | QUIET_BIT) : (y_c | QUIET_BIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_in;
      side <= side_next;
    end
  end

endmodule

// ===== design/fisr_fmul.sv =====
// ----------------------------------------------------------------------------
// fisr_fmul
// Binary32 multiply, round to nearest even: product stage, then
// normalize/round stage.
// ----------------------------------------------------------------------------
module fisr_fmul import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  side_t       side_in,
  output logic        out_valid,
  output logic [31:0] p,
  output side_t       side
);

  mul_mid_t mid;
  side_t    mid_side;
  logic     mid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid      <= fp_mul_pre(a, b);
      mid_side <= side_in;
      p        <= fp_mul_post(mid);
      side     <= mid_side;
    end
  end

endmodule

// ===== design/fisr_fadd.sv =====
// ----------------------------------------------------------------------------
// fisr_fadd
// Binary32 add, round to nearest even: align/add stage, then
// normalize/round stage.
// ----------------------------------------------------------------------------
module fisr_fadd import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  side_t       side_in,
  output logic        out_valid,
  output logic [31:0] s,
  output side_t       side
);

  add_mid_t mid;
  side_t    mid_side;
  logic     mid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid      <= fp_add_pre(a, b);
      mid_side <= side_in;
      s        <= fp_add_post(mid);
      side     <= mid_side;
    end
  end

endmodule
